/* src/albs_pkg.sv */
// package for the addressable led bit stream core
// holds command and register codes, word types and the sequencer state type
// no dependencies
package albs_pkg;

  localparam int BITS_PER_LED = 24;
  localparam logic [4:0] LED_MSB = 5'd23;

  localparam logic [1:0] CMD_STORE_COLOR = 2'd0;
  localparam logic [1:0] CMD_REFRESH     = 2'd1;
  localparam logic [1:0] CMD_TICK        = 2'd2;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;

  localparam logic [CFG_AW-1:0] REG_ENABLED   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_ZERO_DUTY = 3'd1;
  localparam logic [CFG_AW-1:0] REG_ONE_DUTY  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_LEAD      = 3'd3;
  localparam logic [CFG_AW-1:0] REG_TAIL      = 3'd4;

  localparam logic [7:0] SLOTS_RESET = 8'd90;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [9:0]  led_index;
    logic [23:0] color;
  } in_word_t;

  typedef struct packed {
    logic [15:0] duty;
    logic        data_slot;
    logic        loop_end;
    logic        accepted;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_COPY,
    ST_STEP,
    ST_DIV,
    ST_FETCH,
    ST_READ,
    ST_DONE
  } state_t;

endpackage

/* src/albs_ram.sv */
// generic single write port, single read port ram with registered read data
// no dependencies
module albs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* src/addressable_led_bit_stream_core.sv */
// Addressable RGB LED bit-slot streamer. One word in gives one word out. After reset a
// clearing pass zeroes both color stores, during which no word is taken. A color
// write, a refused refresh, a disabled tick or an unused command goes straight to the
// result word. A refresh copies the staged store into the active store one entry per
// cycle over the ram ports, so the stream never shows a half-updated frame. A reset
// slot tick only steps the slot position; a data slot tick finds the led and its bit
// by the bit-serial division of the data slot offset by 24, then does the registered
// read of the active store. A stalled result word holds the core until it is taken.
// Depends on albs_pkg and albs_ram.
module addressable_led_bit_stream_core
  import albs_pkg::*;
#(
  parameter int LED_COUNT = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_data,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int AW       = LED_COUNT > 1 ? $clog2(LED_COUNT) : 1;
  localparam int CW       = $clog2(LED_COUNT + 1);
  localparam int DATA_LEN = LED_COUNT * BITS_PER_LED;
  localparam int DW       = $clog2(DATA_LEN);
  localparam int DCW      = DW > 1 ? $clog2(DW) : 1;

  state_t          state, state_next;
  logic [CW-1:0]   cnt, cnt_next;
  logic [DCW-1:0]  dcnt, dcnt_next;
  logic            enabled, enabled_next;
  logic [15:0]     zero_duty, zero_duty_next;
  logic [15:0]     one_duty, one_duty_next;
  logic [7:0]      lead_slots, lead_slots_next;
  logic [7:0]      tail_slots, tail_slots_next;
  logic [15:0]     slot_position, slot_position_next;
  in_word_t        req, req_next;
  logic [DW-1:0]   dsh, dsh_next;
  logic [4:0]      rem, rem_next;
  logic [AW-1:0]   quo, quo_next;
  out_word_t       res, res_next;
  out_word_t       out_q, out_q_next;
  logic            out_v, out_v_next;

  logic            stg_we, act_we;
  logic [AW-1:0]   stg_waddr, act_waddr;
  logic [23:0]     stg_wdata, act_wdata;
  logic [23:0]     stg_rdata, act_rdata;

  logic [16:0]     total;
  logic [15:0]     data_end;
  logic [15:0]     offset;
  logic [5:0]      trial;
  logic            q_bit;
  logic [23:0]     grb;
  logic [4:0]      bit_pos;

  albs_ram #(.WIDTH(24), .DEPTH(LED_COUNT)) u_staged (
    .clk     (clk),
    .wr_en   (stg_we),
    .wr_addr (stg_waddr),
    .wr_data (stg_wdata),
    .rd_addr (cnt[AW-1:0]),
    .rd_data (stg_rdata)
  );

  albs_ram #(.WIDTH(24), .DEPTH(LED_COUNT)) u_active (
    .clk     (clk),
    .wr_en   (act_we),
    .wr_addr (act_waddr),
    .wr_data (act_wdata),
    .rd_addr (quo),
    .rd_data (act_rdata)
  );

  assign total    = {9'd0, lead_slots} + 17'(DATA_LEN) + {9'd0, tail_slots};
  assign data_end = {8'd0, lead_slots} + 16'(DATA_LEN);
  assign offset   = slot_position - {8'd0, lead_slots};
  assign trial    = {rem, dsh[DW-1]};
  assign q_bit    = (trial >= 6'(BITS_PER_LED));
  // stored as rrggbb, sent as ggrrbb
  assign grb      = {act_rdata[15:8], act_rdata[23:16], act_rdata[7:0]};
  assign bit_pos  = LED_MSB - rem;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = out_v;
  assign out_data  = out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      cnt           <= '0;
      dcnt          <= '0;
      enabled       <= 1'b0;
      zero_duty     <= '0;
      one_duty      <= '0;
      lead_slots    <= SLOTS_RESET;
      tail_slots    <= SLOTS_RESET;
      slot_position <= '0;
      out_v         <= 1'b0;
    end else begin
      state         <= state_next;
      cnt           <= cnt_next;
      dcnt          <= dcnt_next;
      enabled       <= enabled_next;
      zero_duty     <= zero_duty_next;
      one_duty      <= one_duty_next;
      lead_slots    <= lead_slots_next;
      tail_slots    <= tail_slots_next;
      slot_position <= slot_position_next;
      out_v         <= out_v_next;
    end
    req   <= req_next;
    dsh   <= dsh_next;
    rem   <= rem_next;
    quo   <= quo_next;
    res   <= res_next;
    out_q <= out_q_next;
  end

  always_comb begin
    state_next         = state;
    cnt_next           = cnt;
    dcnt_next          = dcnt;
    enabled_next       = enabled;
    zero_duty_next     = zero_duty;
    one_duty_next      = one_duty;
    lead_slots_next    = lead_slots;
    tail_slots_next    = tail_slots;
    slot_position_next = slot_position;
    req_next           = req;
    dsh_next           = dsh;
    rem_next           = rem;
    quo_next           = quo;
    res_next           = res;
    out_q_next         = out_q;
    out_v_next         = out_v;
    stg_we             = 1'b0;
    stg_waddr          = req.led_index[AW-1:0];
    stg_wdata          = req.color;
    act_we             = 1'b0;
    act_waddr          = cnt[AW-1:0];
    act_wdata          = '0;

    if (cfg_we) begin
      case (cfg_addr)
        REG_ENABLED:   enabled_next    = cfg_wdata[0];
        REG_ZERO_DUTY: zero_duty_next  = cfg_wdata;
        REG_ONE_DUTY:  one_duty_next   = cfg_wdata;
        REG_LEAD:      lead_slots_next = cfg_wdata[7:0];
        REG_TAIL:      tail_slots_next = cfg_wdata[7:0];
        default: ;
      endcase
    end

    if (out_v && out_ready) begin
      out_v_next = 1'b0;
    end

    case (state)
      ST_CLEAR: begin
        stg_we    = 1'b1;
        stg_waddr = cnt[AW-1:0];
        stg_wdata = '0;
        act_we    = 1'b1;
        if (cnt == CW'(LED_COUNT - 1)) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt + CW'(1);
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          req_next   = in_data;
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        res_next   = '0;
        state_next = ST_DONE;
        case (req.cmd)
          CMD_STORE_COLOR: begin
            if ({1'b0, req.led_index} < 11'(LED_COUNT)) begin
              stg_we            = 1'b1;
              res_next.accepted = 1'b1;
            end
          end
          CMD_REFRESH: begin
            if (enabled) begin
              res_next.accepted = 1'b1;
              cnt_next          = '0;
              state_next        = ST_COPY;
            end
          end
          CMD_TICK: begin
            res_next.accepted = 1'b1;
            if (enabled) begin
              // position left past the loop by a shorter lead or tail restarts it
              if ({1'b0, slot_position} >= total) begin
                slot_position_next = '0;
              end
              state_next = ST_STEP;
            end
          end
          default: ;
        endcase
      end

      ST_COPY: begin
        // read entry cnt, write entry cnt - 1 from the previous read
        act_we    = (cnt != '0);
        act_waddr = AW'(cnt - CW'(1));
        act_wdata = stg_rdata;
        if (cnt == CW'(LED_COUNT)) begin
          cnt_next   = '0;
          state_next = ST_DONE;
        end else begin
          cnt_next = cnt + CW'(1);
        end
      end

      ST_STEP: begin
        if ({1'b0, slot_position} == total - 17'd1) begin
          res_next.loop_end  = 1'b1;
          slot_position_next = '0;
        end else begin
          slot_position_next = slot_position + 16'd1;
        end
        if (slot_position >= {8'd0, lead_slots} && slot_position < data_end) begin
          dsh_next   = offset[DW-1:0];
          rem_next   = '0;
          quo_next   = '0;
          dcnt_next  = '0;
          state_next = ST_DIV;
        end else begin
          state_next = ST_DONE;
        end
      end

      ST_DIV: begin
        // restoring division by 24, one quotient bit per cycle
        if (q_bit) begin
          rem_next = 5'(trial - 6'(BITS_PER_LED));
        end else begin
          rem_next = trial[4:0];
        end
        quo_next = AW'({quo, q_bit});
        dsh_next = dsh << 1;
        if (dcnt == DCW'(DW - 1)) begin
          state_next = ST_FETCH;
        end else begin
          dcnt_next = dcnt + DCW'(1);
        end
      end

      ST_FETCH: begin
        // quo is final now, the active store read is under way
        state_next = ST_READ;
      end

      ST_READ: begin
        // active store data for led quo arrives here
        res_next.data_slot = 1'b1;
        res_next.duty      = grb[bit_pos] ? one_duty : zero_duty;
        state_next         = ST_DONE;
      end

      ST_DONE: begin
        if (!out_v || out_ready) begin
          out_q_next = res;
          out_v_next = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

endmodule
